[rtl/core/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/sit_pkg.sv]
`default_nettype none
package sit_pkg;

	localparam int COORD_FRAC_BITS = 16;

	localparam int COORD_W = 25;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int LIM_W   = 32;
	localparam int TOL_W   = 20;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4295);

	// tolerance is in 2^-32 deg^2, products are in 2^-(2F) deg^2
	localparam int ZERO_SHIFT = 32 - 2 * COORD_FRAC_BITS;
	localparam int BOUND_RSH  = (ZERO_SHIFT >= 0) ? ZERO_SHIFT : 0;
	localparam int BOUND_LSH  = (ZERO_SHIFT < 0) ? -ZERO_SHIFT : 0;

	localparam logic signed [LIM_W-1:0] LAT_LIM = LIM_W'(90 * (2 ** COORD_FRAC_BITS));
	localparam logic signed [LIM_W-1:0] LON_LIM = LIM_W'(180 * (2 ** COORD_FRAC_BITS));

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;

	typedef enum logic [1:0] {
		REL_GENERAL   = 2'd0,
		REL_COLLINEAR = 2'd1,
		REL_PARALLEL  = 2'd2,
		REL_INVALID   = 2'd3
	} relation_t;

endpackage
`default_nettype wire

[rtl/core/segment_intersection_test.sv]
// channel       | signals                                      | handshake
// --------------+----------------------------------------------+---------------------------
// item in       | a_/b_ lat/lon start/end (8 x 25b signed)     | start, taken when !busy
// result out    | intersects, bad_coordinate, relation         | done, one-cycle strobe
// tolerance cfg | cfg_data (20b)                               | cfg_write
//
// one transaction per clock; busy never rises
// pipeline: input register, differences, six parallel products,
// cross-product subtraction, then the near-zero and sign tests into the result register
// the 26x26 product stage sets the clock period
// arst_n clears the stage valid bits and reloads the tolerance to its default
// results cannot be stalled: done is high for exactly one cycle per transaction
`default_nettype none
`include "assert_macros.svh"
module segment_intersection_test import sit_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [COORD_W-1:0] a_lat_start,
	input  wire logic signed [COORD_W-1:0] a_lon_start,
	input  wire logic signed [COORD_W-1:0] a_lat_end,
	input  wire logic signed [COORD_W-1:0] a_lon_end,
	input  wire logic signed [COORD_W-1:0] b_lat_start,
	input  wire logic signed [COORD_W-1:0] b_lon_start,
	input  wire logic signed [COORD_W-1:0] b_lat_end,
	input  wire logic signed [COORD_W-1:0] b_lon_end,
	input  wire logic               cfg_write,
	input  wire logic [TOL_W-1:0]   cfg_data,
	output logic                    done,
	output logic                    intersects,
	output logic                    bad_coordinate,
	output logic [1:0]              relation
);

	logic [TOL_W-1:0] tol_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// stage 1: captured coordinates
	coord_t a_lat1_s1, a_lon1_s1, a_lat2_s1, a_lon2_s1;
	coord_t b_lat1_s1, b_lon1_s1, b_lat2_s1, b_lon2_s1;

	// stage 2: differences and flags
	diff_t dlat_a_s2, dlon_a_s2, dlat_b_s2, dlon_b_s2, dlat0_s2, dlon0_s2;
	logic  bad_s2, box_s2;

	// stage 3: products
	prod_t p_ua0_s3, p_ua1_s3, p_ub0_s3, p_ub1_s3, p_den0_s3, p_den1_s3;
	logic  bad_s3, box_s3;

	// stage 4: cross products
	cross_t ua_s4, ub_s4, den_s4;
	logic   bad_s4, box_s4;

	// stage 5: result
	logic      hit_s5, bad_s5;
	relation_t rel_s5;

	logic [CROSS_W-1:0] zero_bound;
	logic [CROSS_W-1:0] ua_mag, ub_mag, den_mag;
	logic               ua_zero, ub_zero, den_zero;
	logic               ua_in, ub_in;
	logic               hit_next;
	relation_t          rel_next;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (cfg_write) begin
				tol_q <= cfg_data;
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// ---------------- stage 1 -> 2: range check, differences, box test
	logic   range_ok;
	logic   box_hit;
	coord_t lo_lat, hi_lat, lo_lon, hi_lon;
	coord_t lat_pts [4];
	coord_t lon_pts [4];

	always_comb begin
		lat_pts[0] = a_lat1_s1;
		lat_pts[1] = a_lat2_s1;
		lat_pts[2] = b_lat1_s1;
		lat_pts[3] = b_lat2_s1;
		lon_pts[0] = a_lon1_s1;
		lon_pts[1] = a_lon2_s1;
		lon_pts[2] = b_lon1_s1;
		lon_pts[3] = b_lon2_s1;
		range_ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (LIM_W'(lat_pts[i]) < -LAT_LIM || LIM_W'(lat_pts[i]) > LAT_LIM) begin
				range_ok = 1'b0;
			end
			if (LIM_W'(lon_pts[i]) < -LON_LIM || LIM_W'(lon_pts[i]) > LON_LIM) begin
				range_ok = 1'b0;
			end
		end
	end

	// B's box with corners put in order
	always_comb begin
		lo_lat  = (b_lat1_s1 < b_lat2_s1) ? b_lat1_s1 : b_lat2_s1;
		hi_lat  = (b_lat1_s1 < b_lat2_s1) ? b_lat2_s1 : b_lat1_s1;
		lo_lon  = (b_lon1_s1 < b_lon2_s1) ? b_lon1_s1 : b_lon2_s1;
		hi_lon  = (b_lon1_s1 < b_lon2_s1) ? b_lon2_s1 : b_lon1_s1;
		box_hit = (a_lat1_s1 >= lo_lat && a_lat1_s1 <= hi_lat &&
		           a_lon1_s1 >= lo_lon && a_lon1_s1 <= hi_lon) ||
		          (a_lat2_s1 >= lo_lat && a_lat2_s1 <= hi_lat &&
		           a_lon2_s1 >= lo_lon && a_lon2_s1 <= hi_lon);
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			a_lat1_s1 <= a_lat_start;
			a_lon1_s1 <= a_lon_start;
			a_lat2_s1 <= a_lat_end;
			a_lon2_s1 <= a_lon_end;
			b_lat1_s1 <= b_lat_start;
			b_lon1_s1 <= b_lon_start;
			b_lat2_s1 <= b_lat_end;
			b_lon2_s1 <= b_lon_end;
		end

		dlat_a_s2 <= DIFF_W'(a_lat2_s1) - DIFF_W'(a_lat1_s1);
		dlon_a_s2 <= DIFF_W'(a_lon2_s1) - DIFF_W'(a_lon1_s1);
		dlat_b_s2 <= DIFF_W'(b_lat2_s1) - DIFF_W'(b_lat1_s1);
		dlon_b_s2 <= DIFF_W'(b_lon2_s1) - DIFF_W'(b_lon1_s1);
		dlat0_s2  <= DIFF_W'(a_lat1_s1) - DIFF_W'(b_lat1_s1);
		dlon0_s2  <= DIFF_W'(a_lon1_s1) - DIFF_W'(b_lon1_s1);
		bad_s2    <= !range_ok;
		box_s2    <= box_hit;

		// six independent 26x26 products
		p_ua0_s3  <= dlon_b_s2 * dlat0_s2;
		p_ua1_s3  <= dlat_b_s2 * dlon0_s2;
		p_ub0_s3  <= dlon_a_s2 * dlat0_s2;
		p_ub1_s3  <= dlat_a_s2 * dlon0_s2;
		p_den0_s3 <= dlat_b_s2 * dlon_a_s2;
		p_den1_s3 <= dlon_b_s2 * dlat_a_s2;
		bad_s3    <= bad_s2;
		box_s3    <= box_s2;

		ua_s4  <= CROSS_W'(p_ua0_s3) - CROSS_W'(p_ua1_s3);
		ub_s4  <= CROSS_W'(p_ub0_s3) - CROSS_W'(p_ub1_s3);
		den_s4 <= CROSS_W'(p_den0_s3) - CROSS_W'(p_den1_s3);
		bad_s4 <= bad_s3;
		box_s4 <= box_s3;

		hit_s5 <= hit_next;
		bad_s5 <= bad_s4;
		rel_s5 <= rel_next;
	end

	// ---------------- stage 4 -> 5: near-zero and sign tests
	always_comb begin
		zero_bound = (CROSS_W'(tol_q) << BOUND_LSH) >> BOUND_RSH;
		ua_mag     = ua_s4[CROSS_W-1]  ? CROSS_W'(-ua_s4)  : CROSS_W'(ua_s4);
		ub_mag     = ub_s4[CROSS_W-1]  ? CROSS_W'(-ub_s4)  : CROSS_W'(ub_s4);
		den_mag    = den_s4[CROSS_W-1] ? CROSS_W'(-den_s4) : CROSS_W'(den_s4);
		ua_zero    = ua_mag <= zero_bound;
		ub_zero    = ub_mag <= zero_bound;
		den_zero   = den_mag <= zero_bound;
		// 0 <= u/den <= 1 without dividing
		if (den_s4 > 0) begin
			ua_in = ua_s4 >= 0 && ua_s4 <= den_s4;
			ub_in = ub_s4 >= 0 && ub_s4 <= den_s4;
		end else begin
			ua_in = ua_s4 <= 0 && ua_s4 >= den_s4;
			ub_in = ub_s4 <= 0 && ub_s4 >= den_s4;
		end
	end

	always_comb begin
		hit_next = 1'b0;
		rel_next = REL_GENERAL;
		if (bad_s4) begin
			rel_next = REL_INVALID;
		end else if (den_zero) begin
			if (ua_zero && ub_zero) begin
				rel_next = REL_COLLINEAR;
				hit_next = box_s4;
			end else begin
				rel_next = REL_PARALLEL;
			end
		end else begin
			hit_next = ua_in && ub_in;
		end
	end

	assign done           = valid_s5;
	assign intersects     = hit_s5;
	assign bad_coordinate = bad_s5;
	assign relation       = rel_s5;

	`ASSERT_IMPLIES(a_bad_matches_rel, clk, arst_n, done, bad_coordinate == (relation == REL_INVALID))
	`ASSERT_IMPLIES(a_hit_needs_rel, clk, arst_n, done && intersects, relation == REL_GENERAL || relation == REL_COLLINEAR)
	`ASSERT_IMPLIES(a_done_latency, clk, arst_n, done, $past(start && !busy, 5))
	`ASSERT_NEXT(a_accept_flows, clk, arst_n, start && !busy, valid_s1)

endmodule
`default_nettype wire
